// ===== sv/assert_macros.svh =====
// Assertion helpers used by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RQSS_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("%m: assertion failed");

// Next-cycle implication, disabled during reset.
`define RQSS_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("%m: assertion failed");

`endif

// ===== sv/rqss_pkg.sv =====
`default_nettype none
package rqss_pkg;

    localparam int MASK_BITS     = 8;
    localparam int NUM_PATHS_DEF = 8;
    localparam int QUOTA_W       = 8;
    localparam int LEN_W         = 16;
    localparam int DIV_W         = LEN_W + 1;
    localparam int DIV_CNT_W     = $clog2(DIV_W + 1);
    localparam int PATH_W        = 3;
    localparam int LIMIT_W       = 24;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 8;

    localparam logic [QUOTA_W-1:0] QUOTA_MAX     = 8'd255;
    localparam logic [QUOTA_W-1:0] TOTAL_RESET   = 8'd100;
    localparam logic [QUOTA_W-1:0] SHARE_RESET   = 8'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SEGMENTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOW_ONE_SHARE = 2'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage
`default_nettype wire

// ===== sv/ratio_quota_subflow_scheduler.sv =====
// Ratio quota path scheduler, one segment per request.
// Input channel i_valid/o_ready carries eligible and send-ready masks, the
// segment length and the path MSS. Output channel o_valid/i_ready returns
// found, chosen_path and send_limit: exactly one result per request.
// Config: i_cfg_we writes i_cfg_data into total_segments (index 0) or
// flow_one_share (index 1) at the clock edge; write only while idle.
// Flow: a scan checks one path at a time (up to 8), then a decision step;
// a round restart adds a second scan and decision. Segments longer than
// the MSS get their segment count from the divider: a start, one shift
// per quotient bit of the 17-bit dividend and a hand-off. Then an update
// step (quota add and the split-by-MSS multiply) and an output step.
// One request is in work at a time; o_ready is high only while idle, and
// a new request may enter while the previous result is still held.
// Reset (i_rst_n low, synchronous) clears all quotas and the active share,
// loads the register reset values and empties the output register.
// When the receiver stalls, the result holds in the output register and a
// finished computation waits until that register frees.
`default_nettype none
module ratio_quota_subflow_scheduler
    import rqss_pkg::*;
#(
    parameter int NUM_PATHS = NUM_PATHS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [MASK_BITS-1:0]  i_eligible_mask,
    input  wire logic [MASK_BITS-1:0]  i_send_ready_mask,
    input  wire logic [LEN_W-1:0]      i_segment_length,
    input  wire logic [LEN_W-1:0]      i_path_mss,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic                       o_found,
    output logic [PATH_W-1:0]          o_chosen_path,
    output logic [LIMIT_W-1:0]         o_send_limit,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W    = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
    localparam int SCAN_LEN = (NUM_PATHS < MASK_BITS) ? NUM_PATHS : MASK_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_CHECK, S_DIV, S_UPDATE, S_DONE
    } t_state;

    t_state               r_state;
    logic [QUOTA_W-1:0]   r_total;
    logic [QUOTA_W-1:0]   r_flow_one;
    logic [QUOTA_W-1:0]   r_active;
    logic [QUOTA_W-1:0]   r_quota [NUM_PATHS];
    logic [MASK_BITS-1:0] r_elig;
    logic [MASK_BITS-1:0] r_send_rdy;
    logic [LEN_W-1:0]     r_len;
    logic [LEN_W-1:0]     r_mss;
    logic [IDX_W-1:0]     r_idx;
    logic [IDX_W-1:0]     r_pick;
    logic                 r_pick_v;
    logic                 r_cons;
    logic                 r_notfull;
    logic                 r_pass;
    logic [QUOTA_W-1:0]   r_split;
    logic [QUOTA_W-1:0]   r_add;
    logic                 r_found;
    logic [LIMIT_W-1:0]   r_limit;
    logic                 r_div_start;
    logic                 r_out_valid;
    logic                 r_out_found;
    logic [PATH_W-1:0]    r_out_path;
    logic [LIMIT_W-1:0]   r_out_limit;

    logic [IDX_W-1:0]   rd_addr;
    logic [QUOTA_W-1:0] q;
    logic [QUOTA_W-1:0] share;
    logic [31:0]        idx_ext;
    logic [31:0]        pick_ext;
    logic [31:0]        elig_ext;
    logic               cur_elig;
    logic               pick_rdy;
    logic               all_full;
    logic [QUOTA_W:0]   quota_sum;
    logic [QUOTA_W-1:0] quota_sat;
    logic [QUOTA_W-1:0] add_sat;
    logic [DIV_W-1:0]   dividend;
    logic [DIV_W-1:0]   quotient;
    logic [LEN_W-1:0]   mss_in;
    t_div_status        div_status;

    always_comb begin
        rd_addr   = (r_state == S_UPDATE) ? r_pick : r_idx;
        q         = r_quota[rd_addr];
        share     = r_idx[0] ? (r_total - r_active) : r_active;
        idx_ext   = 32'(r_idx);
        pick_ext  = 32'(r_pick);
        elig_ext  = 32'(r_elig);
        cur_elig  = r_elig[idx_ext[2:0]];
        pick_rdy  = r_send_rdy[pick_ext[2:0]];
        all_full  = r_cons && !r_notfull;
        quota_sum = {1'b0, q} + {1'b0, r_add};
        quota_sat = quota_sum[QUOTA_W] ? QUOTA_MAX : quota_sum[QUOTA_W-1:0];
        add_sat   = (|quotient[DIV_W-1:QUOTA_W]) ? QUOTA_MAX : quotient[QUOTA_W-1:0];
        dividend  = {1'b0, r_len} + {1'b0, r_mss} - DIV_W'(1);
        mss_in    = (i_path_mss == '0) ? LEN_W'(1) : i_path_mss;
    end

    rqss_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (dividend),
        .i_divisor  (r_mss),
        .o_quotient (quotient),
        .o_status   (div_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= TOTAL_RESET;
            r_flow_one  <= SHARE_RESET;
            r_active    <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_PATHS; i++) begin
                r_quota[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TOTAL_SEGMENTS: r_total    <= i_cfg_data;
                    CFG_FLOW_ONE_SHARE: r_flow_one <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && i_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_elig     <= i_eligible_mask;
                        r_send_rdy <= i_send_ready_mask;
                        r_len      <= i_segment_length;
                        r_mss      <= mss_in;
                        r_idx      <= '0;
                        r_pass     <= 1'b0;
                        r_pick_v   <= 1'b0;
                        r_cons     <= 1'b0;
                        r_notfull  <= 1'b0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (cur_elig && share != '0 && q != '0 && q < share) begin
                        r_cons    <= 1'b1;
                        r_notfull <= 1'b1;
                        r_pick    <= r_idx;
                        r_pick_v  <= 1'b1;
                        r_split   <= share - q;
                        r_state   <= S_CHECK;
                    end else begin
                        if (cur_elig) begin
                            r_cons <= 1'b1;
                            if (share != '0 && q == '0) begin
                                r_notfull <= 1'b1;
                                r_pick    <= r_idx;
                                r_pick_v  <= 1'b1;
                                r_split   <= share;
                            end
                        end
                        if (r_idx == IDX_W'(SCAN_LEN - 1)) begin
                            r_state <= S_CHECK;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_CHECK: begin
                    if (all_full && !r_pass) begin
                        for (int i = 0; i < NUM_PATHS; i++) begin
                            if (i < MASK_BITS && elig_ext[i[4:0]]) begin
                                r_quota[i] <= '0;
                            end
                        end
                        r_active  <= r_flow_one;
                        r_pass    <= 1'b1;
                        r_idx     <= '0;
                        r_pick_v  <= 1'b0;
                        r_cons    <= 1'b0;
                        r_notfull <= 1'b0;
                        r_state   <= S_SCAN;
                    end else if (all_full || !r_pick_v || !pick_rdy) begin
                        r_found <= 1'b0;
                        r_limit <= '0;
                        r_state <= S_DONE;
                    end else if (r_len > r_mss) begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end else begin
                        r_add   <= QUOTA_W'(1);
                        r_state <= S_UPDATE;
                    end
                end
                S_DIV: begin
                    r_div_start <= 1'b0;
                    if (div_status.done) begin
                        r_add   <= add_sat;
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_quota[r_pick] <= quota_sat;
                    r_found         <= 1'b1;
                    r_limit         <= LIMIT_W'(r_split) * LIMIT_W'(r_mss);
                    r_state         <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= r_found;
                        r_out_path  <= r_found ? pick_ext[PATH_W-1:0] : '0;
                        r_out_limit <= r_limit;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_found       = r_out_found;
    assign o_chosen_path = r_out_path;
    assign o_send_limit  = r_out_limit;

`include "assert_macros.svh"

    `RQSS_ASSERT_IMP(a_idle_div_quiet, i_clk, i_rst_n, o_ready, !div_status.busy)
    `RQSS_ASSERT_IMP(a_div_done_in_div, i_clk, i_rst_n, div_status.done, r_state == S_DIV)
    `RQSS_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, o_valid && !o_found, o_send_limit == '0 && o_chosen_path == '0)
    `RQSS_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

endmodule
`default_nettype wire

// ===== sv/rqss_divider.sv =====
`default_nettype none
module rqss_divider
    import rqss_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [LEN_W-1:0] i_divisor,
    output logic      [DIV_W-1:0] o_quotient,
    output t_div_status           o_status
);

    logic [LEN_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [LEN_W-1:0]     r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_W-1:0] w;
    logic [DIV_W-1:0] diff;
    logic             ge;
    logic [LEN_W-1:0] n_rem;

    always_comb begin
        w     = {r_rem, r_quo[DIV_W-1]};
        ge    = (w >= {1'b0, r_div});
        diff  = w - {1'b0, r_div};
        n_rem = ge ? diff[LEN_W-1:0] : w[LEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quo  <= {r_quo[DIV_W-2:0], ge};
                r_cnt  <= r_cnt + 1'b1;
                r_done <= (r_cnt == DIV_CNT_W'(DIV_W - 1));
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_quotient    = r_quo;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

endmodule
`default_nettype wire
